>>> rtl/opl_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package opl_pkg;

    localparam int OPL_MAX_ENTRIES = 64;
    localparam int REQ_W           = 3;
    localparam int POS_W           = 7;
    localparam int DATA_W          = 32;

    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    typedef struct packed {
        logic cap;
        logic rd_single;
        logic cap_data;
        logic run;
        logic ins_wr;
        logic dec;
        logic clr;
        logic load_out;
    } opl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic             err;
        logic             scan_done;
    } opl_stat_t;

endpackage

>>> rtl/opl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module opl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/opl_datapath.sv
// Datapath: request registers, element store, scan pointer, count and result registers.
module opl_datapath import opl_pkg::*; #(
    parameter int MAX_ENTRIES = OPL_MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  opl_cmd_t                 cmd,
    output opl_stat_t                stat,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     status,
    output logic signed [DATA_W-1:0] read_data,
    output logic [POS_W-1:0]         found_position,
    output logic [POS_W-1:0]         count,
    output logic                     is_empty
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [REQ_W-1:0]  op_reg, op_next;
    logic              err_reg, err_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CW-1:0]     found_reg, found_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              ostat_reg, ostat_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic [POS_W-1:0]  ofound_reg, ofound_next;
    logic [POS_W-1:0]  ocount_reg, ocount_next;
    logic              oempty_reg, oempty_next;

    logic [CW-1:0]     in_pos_x, reg_pos_x, count_x, ptr_x, pos_m1_x;
    logic              pos_bad, ins_bad, err_in;
    logic              is_ins, is_loc, more, match;
    logic [CNT_W-1:0]  ptr_m1;
    logic [AW-1:0]     scan_addr, pos_m1;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    assign in_pos_x  = {{(CW-POS_W){1'b0}}, position};
    assign reg_pos_x = {{(CW-POS_W){1'b0}}, pos_reg};
    assign count_x   = {{(CW-CNT_W){1'b0}}, count_reg};
    assign ptr_x     = {{(CW-CNT_W){1'b0}}, ptr_reg};
    assign pos_m1_x  = reg_pos_x - CW'(1);
    assign pos_m1    = pos_m1_x[AW-1:0];

    assign pos_bad = (in_pos_x == '0) || (in_pos_x > count_x);
    assign ins_bad = (in_pos_x == '0) || (in_pos_x > count_x + CW'(1))
                     || (count_x >= CW'(MAX_ENTRIES));

    always_comb
    begin
        unique case (req_type)
            REQ_READ:   err_in = pos_bad;
            REQ_LOCATE: err_in = 1'b0;
            REQ_INSERT: err_in = ins_bad;
            REQ_DELETE: err_in = pos_bad;
            REQ_CLEAR:  err_in = 1'b0;
            default:    err_in = 1'b1;
        endcase
    end

    assign is_ins    = (op_reg == REQ_INSERT);
    assign is_loc    = (op_reg == REQ_LOCATE);
    assign more      = is_ins ? (ptr_x >= reg_pos_x) : (ptr_x < count_x);
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign scan_addr = is_ins ? ptr_m1[AW-1:0] : ptr_reg[AW-1:0];
    assign match     = pend_reg && (rdata == val_reg);

    assign raddr = cmd.rd_single ? pos_m1 : scan_addr;
    assign we    = (cmd.run && pend_reg && !is_loc) || cmd.ins_wr;
    assign wdata = cmd.ins_wr ? val_reg : rdata;

    always_comb
    begin
        priority if (cmd.ins_wr)
        begin
            waddr = pos_m1;
        end
        else if (is_ins)
        begin
            waddr = pend_addr_reg + AW'(1);
        end
        else
        begin
            waddr = pend_addr_reg - AW'(1);
        end
    end

    opl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        op_next        = op_reg;
        err_next       = err_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        data_next      = data_reg;
        ostat_next     = ostat_reg;
        odata_next     = odata_reg;
        ofound_next    = ofound_reg;
        ocount_next    = ocount_reg;
        oempty_next    = oempty_reg;

        if (cmd.cap)
        begin
            op_next    = req_type;
            err_next   = err_in;
            pos_next   = position;
            val_next   = value;
            pend_next  = 1'b0;
            found_next = '0;
            data_next  = '0;
            unique case (req_type)
                REQ_INSERT: ptr_next = count_reg;
                REQ_DELETE: ptr_next = in_pos_x[CNT_W-1:0];
                default:    ptr_next = '0;
            endcase
        end

        if (cmd.run)
        begin
            pend_next = more;
            if (more)
            begin
                pend_addr_next = scan_addr;
                ptr_next       = is_ins ? ptr_m1 : ptr_reg + CNT_W'(1);
            end
            if (is_loc && match)
            begin
                found_next = {{(CW-AW){1'b0}}, pend_addr_reg} + CW'(1);
            end
        end

        if (cmd.cap_data)
        begin
            data_next = rdata;
        end

        priority if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.ins_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        if (cmd.load_out)
        begin
            ostat_next  = err_reg;
            odata_next  = data_reg;
            ofound_next = found_reg[POS_W-1:0];
            ocount_next = count_x[POS_W-1:0];
            oempty_next = (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        err_reg       <= err_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        data_reg      <= data_next;
        ostat_reg     <= ostat_next;
        odata_reg     <= odata_next;
        ofound_reg    <= ofound_next;
        ocount_reg    <= ocount_next;
        oempty_reg    <= oempty_next;
    end

    assign stat.op        = op_reg;
    assign stat.err       = err_reg;
    assign stat.scan_done = (is_loc && match) || (!more && !pend_reg);

    assign status         = ostat_reg;
    assign read_data      = odata_reg;
    assign found_position = ofound_reg;
    assign count          = ocount_reg;
    assign is_empty       = oempty_reg;

endmodule

>>> rtl/opl_ctrl.sv
// Controller: request sequencing state machine and result beat handshake.
module opl_ctrl import opl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output opl_cmd_t  cmd,
    input  opl_stat_t stat
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DEC      = 3'd1;
    localparam logic [2:0] S_RD_ISSUE = 3'd2;
    localparam logic [2:0] S_RD_DATA  = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_INS_WR   = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                priority if (stat.err)
                begin
                    state_next = S_FIN;
                end
                else if (stat.op == REQ_READ)
                begin
                    state_next = S_RD_ISSUE;
                end
                else if (stat.op == REQ_CLEAR)
                begin
                    cmd.clr    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_single = 1'b1;
                state_next    = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.cap_data = 1'b1;
                state_next   = S_FIN;
            end
            S_SCAN:
            begin
                cmd.run = 1'b1;
                if (stat.scan_done)
                begin
                    priority if (stat.op == REQ_INSERT)
                    begin
                        state_next = S_INS_WR;
                    end
                    else if (stat.op == REQ_DELETE)
                    begin
                        cmd.dec    = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

endmodule

>>> rtl/ordered_position_list.sv
// Top level of the ordered position list: controller, datapath and element store.
//
// Holds up to MAX_ENTRIES signed 32-bit elements in one RAM with one write and
// one registered read port, plus an element count. One request is handled at a
// time; in_stall is high from acceptance until the result is loaded into the
// output register, and a held result does not block the next request. Every
// request passes through decode and a final state that loads the result; clear
// and rejected requests go straight from decode to the final state, and read
// issues one RAM read and captures its data in between. Locate, insert and
// delete stream through the RAM one element per cycle: locate walks until the
// value first appears or the count is reached, delete moves the elements after
// the position down by one, and insert moves the elements from the position on
// up by one and then writes the new value. A result still held by out_stall
// keeps the next request in its final state until that beat leaves. No clearing
// pass after reset: entries beyond the count are never read.
module ordered_position_list import opl_pkg::*; #(
    parameter int MAX_ENTRIES = OPL_MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     status,
    output logic signed [DATA_W-1:0] read_data,
    output logic [POS_W-1:0]         found_position,
    output logic [POS_W-1:0]         count,
    output logic                     is_empty
);

    opl_cmd_t  cmd;
    opl_stat_t stat;

    opl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    opl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .status         (status),
        .read_data      (read_data),
        .found_position (found_position),
        .count          (count),
        .is_empty       (is_empty)
    );

endmodule

>>> dv/tb_ordered_position_list.sv
// Self-checking testbench for ordered_position_list: directed and random requests.
module tb_ordered_position_list import opl_pkg::*; ();

    localparam int LIST_DEPTH = OPL_MAX_ENTRIES;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] read_data;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         count;
        logic                     is_empty;
    } list_reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     status;
    logic signed [DATA_W-1:0] read_data;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         count;
    logic                     is_empty;

    logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
    int                       list_len = 0;
    list_reply_t              pending_replies [$];
    int                       mismatches = 0;

    bit no_idle = 1'b0;
    bit burst = 1'b0;
    bit growing = 1'b1;
    int holdoff_left = 0;
    int stall_left = 0;
    int free_left = 0;

    ordered_position_list u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .found_position (found_position),
        .count          (count),
        .is_empty       (is_empty)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else if (roll < 10)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (roll < 15)
            return -1;
        else if (roll < 30)
            return $urandom_range(0, 4);
        else
            return $urandom;
    endfunction

    function automatic int bad_position(input int limit);
        if (limit >= POS_MAX || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(limit + 1, POS_MAX);
    endfunction

    task automatic apply_to_list(input logic [REQ_W-1:0] kind, input int pos,
                                 input logic signed [DATA_W-1:0] val,
                                 output list_reply_t reply);
        int i;
        reply = '0;
        case (kind)
            REQ_READ:
            begin
                if (pos < 1 || pos > list_len)
                    reply.status = 1'b1;
                else
                    reply.read_data = list_mem[pos-1];
            end
            REQ_LOCATE:
            begin
                for (i = 0; i < list_len; i++)
                    if (reply.found_position == 0 && list_mem[i] == val)
                        reply.found_position = POS_W'(i + 1);
            end
            REQ_INSERT:
            begin
                if (pos < 1 || pos > list_len + 1 || list_len >= LIST_DEPTH)
                    reply.status = 1'b1;
                else
                begin
                    for (i = list_len; i > pos - 1; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos-1] = val;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    reply.status = 1'b1;
                else
                begin
                    for (i = pos; i < list_len; i++)
                        list_mem[i-1] = list_mem[i];
                    list_len--;
                end
            end
            REQ_CLEAR:
                list_len = 0;
            default:
                reply.status = 1'b1;
        endcase
        reply.count = list_len[POS_W-1:0];
        reply.is_empty = (list_len == 0);
    endtask

    task automatic push_request(input logic [REQ_W-1:0] kind, input int pos,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        list_reply_t reply;
        gap = (no_idle || burst) ? 0 : gap_length();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            req_type = REQ_W'($urandom);
            position = POS_W'($urandom);
            value = $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        req_type = kind;
        position = pos[POS_W-1:0];
        value = val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_to_list(kind, pos, val, reply);
        pending_replies.push_back(reply);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive_out_stall
        if (holdoff_left > 0)
        begin
            out_stall = 1'b1;
            holdoff_left--;
        end
        else if (no_idle)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if (free_left > 0)
                free_left--;
            else
            begin
                stall_left = gap_length();
                free_left = $urandom_range(0, 12);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        list_reply_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with no request outstanding");
                mismatches++;
            end
            else
            begin
                exp = pending_replies.pop_front();
                if (status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, status);
                    mismatches++;
                end
                if (read_data !== exp.read_data)
                begin
                    $error("read_data: expected %0d, got %0d", exp.read_data, read_data);
                    mismatches++;
                end
                if (found_position !== exp.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           exp.found_position, found_position);
                    mismatches++;
                end
                if (count !== exp.count)
                begin
                    $error("count: expected %0d, got %0d", exp.count, count);
                    mismatches++;
                end
                if (is_empty !== exp.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", exp.is_empty, is_empty);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_empty_list();
        push_request(REQ_READ, 0, 0);
        push_request(REQ_READ, 1, 0);
        push_request(REQ_LOCATE, 0, 0);
        push_request(REQ_INSERT, 0, 7);
        push_request(REQ_INSERT, 2, 7);
        push_request(REQ_DELETE, 1, 0);
        push_request(REQ_CLEAR, 0, 0);
        push_request(REQ_UNUSED_FIRST, POS_MAX, $urandom);
        push_request(REQ_UNUSED_LAST, POS_MAX, -1);
    endtask

    task automatic test_edit_sequence();
        push_request(REQ_INSERT, 1, {1'b1, {(DATA_W-1){1'b0}}});
        push_request(REQ_INSERT, 2, {1'b0, {(DATA_W-1){1'b1}}});
        push_request(REQ_INSERT, 2, -1);
        push_request(REQ_INSERT, 1, 0);
        push_request(REQ_INSERT, list_len + 2, 5);
        push_request(REQ_INSERT, list_len + 1, -1);
        push_request(REQ_READ, 1, 0);
        push_request(REQ_READ, list_len, 0);
        push_request(REQ_READ, list_len + 1, 0);
        push_request(REQ_READ, POS_MAX, 0);
        push_request(REQ_LOCATE, 0, {1'b0, {(DATA_W-1){1'b1}}});
        push_request(REQ_LOCATE, 0, -1);
        push_request(REQ_LOCATE, 0, 12345);
        push_request(REQ_DELETE, 2, 0);
        push_request(REQ_DELETE, list_len, 0);
        push_request(REQ_DELETE, 1, 0);
        push_request(REQ_DELETE, 0, 0);
        push_request(REQ_CLEAR, 3, 0);
        push_request(REQ_READ, 1, 0);
    endtask

    task automatic test_fill_to_capacity();
        while (list_len < LIST_DEPTH)
            push_request(REQ_INSERT, $urandom_range(1, list_len + 1), pick_value());
        push_request(REQ_INSERT, list_len + 1, 1);
        push_request(REQ_INSERT, 1, 1);
        push_request(REQ_READ, LIST_DEPTH, 0);
        push_request(REQ_READ, LIST_DEPTH + 1, 0);
        push_request(REQ_LOCATE, 0, list_mem[LIST_DEPTH-1]);
        push_request(REQ_DELETE, LIST_DEPTH, 0);
        push_request(REQ_DELETE, 1, 0);
    endtask

    task automatic test_output_holdoff();
        int i;
        holdoff_left = 300;
        burst = 1'b1;
        for (i = 0; i < 16; i++)
            push_request(REQ_W'($urandom_range(REQ_READ, REQ_DELETE)),
                         $urandom_range(0, list_len + 1), pick_value());
        burst = 1'b0;
    endtask

    task automatic random_request();
        int roll;
        int pos;
        logic [REQ_W-1:0] kind;
        logic signed [DATA_W-1:0] val;
        roll = $urandom_range(0, 99);
        val = pick_value();
        pos = 0;
        if (roll < 2)
        begin
            kind = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            pos = $urandom_range(0, POS_MAX);
        end
        else if (roll < 4 && !growing)
            kind = REQ_CLEAR;
        else if (roll < 25)
            kind = REQ_READ;
        else if (roll < 45)
        begin
            kind = REQ_LOCATE;
            if (list_len > 0 && $urandom_range(0, 9) < 6)
                val = list_mem[$urandom_range(0, list_len - 1)];
        end
        else if (roll < (growing ? 90 : 60))
            kind = REQ_INSERT;
        else
            kind = REQ_DELETE;

        if (kind == REQ_INSERT)
            pos = ($urandom_range(0, 9) == 0) ? bad_position(list_len + 1)
                                              : $urandom_range(1, list_len + 1);
        else if (kind == REQ_READ || kind == REQ_DELETE)
            pos = (list_len == 0 || $urandom_range(0, 9) == 0) ? bad_position(list_len)
                                                               : $urandom_range(1, list_len);
        push_request(kind, pos, val);

        if (list_len == LIST_DEPTH)
            growing = 1'b0;
        else if (list_len == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 99) == 0)
            growing = !growing;
    endtask

    task automatic test_random_mix(input int n_items);
        int i;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            random_request();
            if ($urandom_range(0, 199) == 0)
                wait_for_results();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        wait_for_results();
        test_edit_sequence();
        wait_for_results();
        test_fill_to_capacity();
        wait_for_results();
        test_output_holdoff();
        wait_for_results();
        test_random_mix(740);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> ordered_position_list.f
rtl/opl_pkg.sv
rtl/opl_ram.sv
rtl/opl_datapath.sv
rtl/opl_ctrl.sv
rtl/ordered_position_list.sv
dv/tb_ordered_position_list.sv
